// File: rtl/core/ccn_pkg.sv
// Shared types, constants and helpers for the capped cylinder normal unit.
`default_nettype none
package ccn_pkg;

  // Coordinate handling
  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned COMP_BITS   = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam int unsigned SEXT_SHIFT  = 16 - COMP_BITS;

  // Fixed widths of the datapath
  localparam int unsigned V_W    = 17;  // point minus centre
  localparam int unsigned SQ_W   = 33;  // one squared difference
  localparam int unsigned DOT_W  = 35;  // v . a
  localparam int unsigned W_W    = 53;  // side vector, signed
  localparam int unsigned MAG_W  = 52;  // side vector magnitude
  localparam int unsigned NRM_W  = 30;  // normalised magnitude
  localparam int unsigned SUM_W  = 62;  // sum of squares
  localparam int unsigned LEN_W  = 31;  // floor square root
  localparam int unsigned NUM_W  = 45;  // division numerator
  localparam int unsigned Q_W    = 15;  // quotient
  localparam int unsigned NORM_TOP = 29;  // largest magnitude lands in [2^29, 2^30)
  localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  // Register map (index = paddr[5:3])
  typedef enum logic [2:0] {
    REG_END_ONE  = 3'd0,
    REG_END_TWO  = 3'd1,
    REG_AXIS     = 3'd2,
    REG_CAP_ONE  = 3'd3,
    REG_CAP_TWO  = 3'd4,
    REG_RADIUS   = 3'd5,
    REG_CAPS_EN  = 3'd6,
    REG_SPARE    = 3'd7
  } reg_idx_e;

  // Surface kind codes
  typedef enum logic [1:0] {
    KIND_SIDE    = 2'd0,
    KIND_CAP_ONE = 2'd1,
    KIND_CAP_TWO = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [47:0] c1;
    logic [47:0] c2;
    logic [47:0] axis;
    logic [47:0] capn1;
    logic [47:0] capn2;
    logic [29:0] r2;
    logic        caps_en;
  } ccn_cfg_t;

  // Item handed from front to back
  typedef struct packed {
    logic [2:0][V_W-1:0] v;
    logic [DOT_W-1:0]    dot;
    kind_e               kind;
    logic [47:0]         capn;
  } ccn_item_t;

  // Sideband carried down the back pipeline
  typedef struct packed {
    kind_e       kind;
    logic [47:0] capn;
    logic        degen;
    logic [2:0]  neg;
  } ccn_side_t;

  // Sign-extend a coordinate from COMP_BITS bits
  function automatic logic signed [15:0] coord_sext(logic [15:0] x);
    logic signed [15:0] t;
    t = signed'(x << SEXT_SHIFT);
    return t >>> SEXT_SHIFT;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ccn_front.sv
// Front end: offsets, cap tests and axis dot product, classifies each item.
`default_nettype none
module ccn_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                in_valid_i,
  input  wire logic [15:0]         point_x_i,
  input  wire logic [15:0]         point_y_i,
  input  wire logic [15:0]         point_z_i,
  input  wire ccn_pkg::ccn_cfg_t   cfg_i,
  output logic                     push_o,
  output ccn_pkg::ccn_item_t       item_o
);

  logic [2:0][15:0] pt;
  assign pt = {point_z_i, point_y_i, point_x_i};

  // stage 1: differences
  logic                              vld1_q;
  logic signed [ccn_pkg::V_W-1:0]    v1_q  [3];
  logic signed [ccn_pkg::V_W-1:0]    d1_q  [3];

  // stage 2: products
  logic                              vld2_q;
  logic signed [ccn_pkg::V_W-1:0]    v2_q  [3];
  logic [ccn_pkg::SQ_W-1:0]          s1_q  [3];
  logic [ccn_pkg::SQ_W-1:0]          s2_q  [3];
  logic signed [32:0]                va_q  [3];

  // stage 3: classified item
  logic                              vld3_q;
  ccn_pkg::ccn_item_t                item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // stage 1 datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        v1_q[k] <= 17'(ccn_pkg::coord_sext(pt[k]))
                 - 17'(ccn_pkg::coord_sext(cfg_i.c1[16*k +: 16]));
        d1_q[k] <= 17'(ccn_pkg::coord_sext(pt[k]))
                 - 17'(ccn_pkg::coord_sext(cfg_i.c2[16*k +: 16]));
      end
    end
  end

  // stage 2 datapath: squares and axis products
  logic signed [33:0] sqa [3];
  logic signed [33:0] sqb [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sqa[k] = 34'(v1_q[k]) * 34'(v1_q[k]);
      sqb[k] = 34'(d1_q[k]) * 34'(d1_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        v2_q[k] <= v1_q[k];
        s1_q[k] <= sqa[k][ccn_pkg::SQ_W-1:0];
        s2_q[k] <= sqb[k][ccn_pkg::SQ_W-1:0];
        va_q[k] <= 33'(v1_q[k]) * 33'(signed'(cfg_i.axis[16*k +: 16]));
      end
    end
  end

  // stage 3: sums, cap tests, classification
  logic [34:0]                       sum1, sum2;
  logic signed [ccn_pkg::DOT_W-1:0]  dot;
  ccn_pkg::ccn_item_t                item_d;
  always_comb begin
    sum1 = 35'(s1_q[0]) + 35'(s1_q[1]) + 35'(s1_q[2]);
    sum2 = 35'(s2_q[0]) + 35'(s2_q[1]) + 35'(s2_q[2]);
    dot  = 35'(va_q[0]) + 35'(va_q[1]) + 35'(va_q[2]);
    for (int k = 0; k < 3; k++) begin
      item_d.v[k] = v2_q[k];
    end
    item_d.dot = dot;
    if (cfg_i.caps_en && (sum1 <= 35'(cfg_i.r2))) begin
      item_d.kind = ccn_pkg::KIND_CAP_ONE;
      item_d.capn = cfg_i.capn1;
    end else if (cfg_i.caps_en && (sum2 <= 35'(cfg_i.r2))) begin
      item_d.kind = ccn_pkg::KIND_CAP_TWO;
      item_d.capn = cfg_i.capn2;
    end else begin
      item_d.kind = ccn_pkg::KIND_SIDE;
      item_d.capn = cfg_i.capn1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign push_o = vld3_q & en_i;
  assign item_o = item_q;

endmodule
`default_nettype wire

// File: rtl/core/ccn_fifo.sv
// Short item queue between the front end and the back end.
`default_nettype none
module ccn_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ccn_pkg::ccn_item_t  data_i,
  input  wire logic                pop_i,
  output ccn_pkg::ccn_item_t       data_o,
  output logic                     empty_o,
  output logic                     full_o
);

  localparam int unsigned PtrW = $clog2(ccn_pkg::Q_DEPTH);

  ccn_pkg::ccn_item_t mem_q [ccn_pkg::Q_DEPTH];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [PtrW:0]      cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PtrW+1)'(ccn_pkg::Q_DEPTH));
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ccn_back.sv
// Back end: side vector, normalisation, square root, divide and result select.
`default_nettype none
module ccn_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                empty_i,
  input  wire ccn_pkg::ccn_item_t  item_i,
  input  wire logic [47:0]         axis_i,
  output logic                     pop_o,
  output logic                     done_o,
  output logic [15:0]              normal_x_o,
  output logic [15:0]              normal_y_o,
  output logic [15:0]              normal_z_o,
  output logic [1:0]               surface_kind_o,
  output logic                     degenerate_o
);

  localparam int unsigned SqSteps  = ccn_pkg::LEN_W;
  localparam int unsigned DivSteps = ccn_pkg::Q_W;

  assign pop_o = !empty_i;

  ccn_pkg::ccn_side_t side_in;
  always_comb begin
    side_in.kind  = item_i.kind;
    side_in.capn  = item_i.capn;
    side_in.degen = 1'b0;
    side_in.neg   = '0;
  end

  // B1: dot * axis
  logic                              b1_vld_q;
  ccn_pkg::ccn_side_t                b1_side_q;
  logic signed [ccn_pkg::V_W-1:0]    b1_v_q  [3];
  logic signed [50:0]                b1_pr_q [3];
  // B2: side vector
  logic                              b2_vld_q;
  ccn_pkg::ccn_side_t                b2_side_q;
  logic signed [ccn_pkg::W_W-1:0]    b2_w_q  [3];
  // B3: magnitude and sign
  logic                              b3_vld_q;
  ccn_pkg::ccn_side_t                b3_side_q;
  logic [ccn_pkg::MAG_W-1:0]         b3_mag_q [3];
  // B4: largest magnitude
  logic                              b4_vld_q;
  ccn_pkg::ccn_side_t                b4_side_q;
  logic [ccn_pkg::MAG_W-1:0]         b4_mag_q [3];
  logic [ccn_pkg::MAG_W-1:0]         b4_mx_q;
  // B5: leading one per byte
  logic                              b5_vld_q;
  ccn_pkg::ccn_side_t                b5_side_q;
  logic [ccn_pkg::MAG_W-1:0]         b5_mag_q [3];
  logic [6:0]                        b5_nz_q;
  logic [2:0]                        b5_pos_q [7];
  // B6: leading one position
  logic                              b6_vld_q;
  ccn_pkg::ccn_side_t                b6_side_q;
  logic [ccn_pkg::MAG_W-1:0]         b6_mag_q [3];
  logic [5:0]                        b6_msb_q;
  // B7: normalised magnitudes
  logic                              b7_vld_q;
  ccn_pkg::ccn_side_t                b7_side_q;
  logic [ccn_pkg::NRM_W-1:0]         b7_mag_q [3];
  // B8: squares
  logic                              b8_vld_q;
  ccn_pkg::ccn_side_t                b8_side_q;
  logic [ccn_pkg::NRM_W-1:0]         b8_mag_q [3];
  logic [59:0]                       b8_sq_q  [3];
  // square root pipeline, entry 0 holds the sum
  logic                              sq_vld_q  [SqSteps+1];
  ccn_pkg::ccn_side_t                sq_side_q [SqSteps+1];
  logic [ccn_pkg::NRM_W-1:0]         sq_mag_q  [SqSteps+1][3];
  logic [ccn_pkg::SUM_W-1:0]         sq_rem_q  [SqSteps+1];
  logic [ccn_pkg::LEN_W-1:0]         sq_root_q [SqSteps+1];
  // divide pipeline, entry 0 holds numerators
  logic                              dv_vld_q  [DivSteps+1];
  ccn_pkg::ccn_side_t                dv_side_q [DivSteps+1];
  logic [ccn_pkg::LEN_W-1:0]         dv_den_q  [DivSteps+1];
  logic [ccn_pkg::NUM_W-1:0]         dv_rem_q  [DivSteps+1][3];
  logic [ccn_pkg::Q_W-1:0]           dv_quo_q  [DivSteps+1][3];

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
      b4_vld_q <= 1'b0;
      b5_vld_q <= 1'b0;
      b6_vld_q <= 1'b0;
      b7_vld_q <= 1'b0;
      b8_vld_q <= 1'b0;
      for (int s = 0; s <= SqSteps; s++) begin
        sq_vld_q[s] <= 1'b0;
      end
      for (int s = 0; s <= DivSteps; s++) begin
        dv_vld_q[s] <= 1'b0;
      end
      done_o <= 1'b0;
    end else begin
      b1_vld_q <= pop_o;
      b2_vld_q <= b1_vld_q;
      b3_vld_q <= b2_vld_q;
      b4_vld_q <= b3_vld_q;
      b5_vld_q <= b4_vld_q;
      b6_vld_q <= b5_vld_q;
      b7_vld_q <= b6_vld_q;
      b8_vld_q <= b7_vld_q;
      sq_vld_q[0] <= b8_vld_q;
      for (int s = 1; s <= SqSteps; s++) begin
        sq_vld_q[s] <= sq_vld_q[s-1];
      end
      dv_vld_q[0] <= sq_vld_q[SqSteps];
      for (int s = 1; s <= DivSteps; s++) begin
        dv_vld_q[s] <= dv_vld_q[s-1];
      end
      done_o <= dv_vld_q[DivSteps];
    end
  end

  // largest magnitude, signs and zero test
  logic [ccn_pkg::MAG_W-1:0] mx01, mx3;
  ccn_pkg::ccn_side_t        b3_side_d, b4_side_d;
  always_comb begin
    mx01 = (b3_mag_q[0] > b3_mag_q[1]) ? b3_mag_q[0] : b3_mag_q[1];
    mx3  = (mx01 > b3_mag_q[2]) ? mx01 : b3_mag_q[2];
    b3_side_d = b2_side_q;
    for (int k = 0; k < 3; k++) begin
      b3_side_d.neg[k] = b2_w_q[k][ccn_pkg::W_W-1];
    end
    b4_side_d       = b3_side_q;
    b4_side_d.degen = (b3_mag_q[0] == '0) && (b3_mag_q[1] == '0) && (b3_mag_q[2] == '0);
  end

  // B1 .. B4
  always_ff @(posedge clk_i) begin
    b1_side_q <= side_in;
    for (int k = 0; k < 3; k++) begin
      b1_v_q[k]  <= signed'(item_i.v[k]);
      b1_pr_q[k] <= 51'(signed'(item_i.dot)) * 51'(signed'(axis_i[16*k +: 16]));
    end
    b2_side_q <= b1_side_q;
    for (int k = 0; k < 3; k++) begin
      b2_w_q[k] <= (53'(b1_v_q[k]) <<< 28) - 53'(b1_pr_q[k]);
    end
    b3_side_q <= b3_side_d;
    for (int k = 0; k < 3; k++) begin
      b3_mag_q[k] <= b2_w_q[k][ccn_pkg::W_W-1] ? ccn_pkg::MAG_W'(-b2_w_q[k])
                                                : ccn_pkg::MAG_W'(b2_w_q[k]);
    end
    b4_side_q <= b4_side_d;
    b4_mag_q  <= b3_mag_q;
    b4_mx_q   <= mx3;
  end

  // B5: per byte leading one of the largest magnitude
  logic [55:0] mx_pad;
  logic [6:0]  nz_d;
  logic [2:0]  pos_d [7];
  always_comb begin
    mx_pad = 56'(b4_mx_q);
    for (int c = 0; c < 7; c++) begin
      nz_d[c]  = |mx_pad[8*c +: 8];
      pos_d[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (mx_pad[8*c + b]) begin
          pos_d[c] = 3'(b);
        end
      end
    end
  end

  // B6: combine bytes
  logic [5:0] msb_d;
  always_comb begin
    msb_d = '0;
    for (int c = 0; c < 7; c++) begin
      if (b5_nz_q[c]) begin
        msb_d = 6'(8*c) + 6'(b5_pos_q[c]);
      end
    end
  end

  // B7: common shift
  logic [ccn_pkg::MAG_W-1:0] shf_d [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (b6_msb_q >= 6'(ccn_pkg::NORM_TOP)) begin
        shf_d[k] = b6_mag_q[k] >> (b6_msb_q - 6'(ccn_pkg::NORM_TOP));
      end else begin
        shf_d[k] = b6_mag_q[k] << (6'(ccn_pkg::NORM_TOP) - b6_msb_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b5_side_q <= b4_side_q;
    b5_mag_q  <= b4_mag_q;
    b5_nz_q   <= nz_d;
    b5_pos_q  <= pos_d;
    b6_side_q <= b5_side_q;
    b6_mag_q  <= b5_mag_q;
    b6_msb_q  <= msb_d;
    b7_side_q <= b6_side_q;
    for (int k = 0; k < 3; k++) begin
      b7_mag_q[k] <= shf_d[k][ccn_pkg::NRM_W-1:0];
    end
    b8_side_q <= b7_side_q;
    b8_mag_q  <= b7_mag_q;
    for (int k = 0; k < 3; k++) begin
      b8_sq_q[k] <= 60'(b7_mag_q[k]) * 60'(b7_mag_q[k]);
    end
    // sum of squares enters the root pipeline
    sq_side_q[0] <= b8_side_q;
    sq_mag_q[0]  <= b8_mag_q;
    sq_rem_q[0]  <= 62'(b8_sq_q[0]) + 62'(b8_sq_q[1]) + 62'(b8_sq_q[2]);
    sq_root_q[0] <= '0;
  end

  // square root, one result bit per stage, most significant first
  for (genvar s = 1; s <= SqSteps; s++) begin : g_sqrt
    localparam int unsigned Bit = SqSteps - s;
    logic [62:0] trial;
    assign trial = ((63'(sq_root_q[s-1]) << 1) + (63'(1) << Bit)) << Bit;
    always_ff @(posedge clk_i) begin
      sq_side_q[s] <= sq_side_q[s-1];
      sq_mag_q[s]  <= sq_mag_q[s-1];
      if (63'(sq_rem_q[s-1]) >= trial) begin
        sq_rem_q[s]  <= sq_rem_q[s-1] - trial[ccn_pkg::SUM_W-1:0];
        sq_root_q[s] <= sq_root_q[s-1] | (ccn_pkg::LEN_W'(1) << Bit);
      end else begin
        sq_rem_q[s]  <= sq_rem_q[s-1];
        sq_root_q[s] <= sq_root_q[s-1];
      end
    end
  end

  // numerators with rounding term
  always_ff @(posedge clk_i) begin
    dv_side_q[0] <= sq_side_q[SqSteps];
    dv_den_q[0]  <= sq_root_q[SqSteps];
    for (int k = 0; k < 3; k++) begin
      dv_rem_q[0][k] <= (ccn_pkg::NUM_W'(sq_mag_q[SqSteps][k]) << 14)
                      + ccn_pkg::NUM_W'(sq_root_q[SqSteps] >> 1);
      dv_quo_q[0][k] <= '0;
    end
  end

  // restoring divide, one quotient bit per stage for all three lanes
  for (genvar s = 1; s <= DivSteps; s++) begin : g_div
    localparam int unsigned Bit = DivSteps - s;
    logic [45:0] dtrial;
    assign dtrial = 46'(dv_den_q[s-1]) << Bit;
    always_ff @(posedge clk_i) begin
      dv_side_q[s] <= dv_side_q[s-1];
      dv_den_q[s]  <= dv_den_q[s-1];
      for (int k = 0; k < 3; k++) begin
        if (46'(dv_rem_q[s-1][k]) >= dtrial) begin
          dv_rem_q[s][k] <= dv_rem_q[s-1][k] - dtrial[ccn_pkg::NUM_W-1:0];
          dv_quo_q[s][k] <= dv_quo_q[s-1][k] | (ccn_pkg::Q_W'(1) << Bit);
        end else begin
          dv_rem_q[s][k] <= dv_rem_q[s-1][k];
          dv_quo_q[s][k] <= dv_quo_q[s-1][k];
        end
      end
    end
  end

  // result select
  ccn_pkg::ccn_side_t     fs;
  logic [2:0][15:0]       nrm_d;
  logic [ccn_pkg::Q_W-1:0] qc;
  logic [1:0]             kind_d;
  logic                   degen_d;
  always_comb begin
    fs      = dv_side_q[DivSteps];
    kind_d  = fs.kind;
    degen_d = 1'b0;
    nrm_d   = '0;
    qc      = '0;
    case (fs.kind)
      ccn_pkg::KIND_CAP_ONE, ccn_pkg::KIND_CAP_TWO: begin
        nrm_d = fs.capn;
      end
      default: begin
        kind_d = ccn_pkg::KIND_SIDE;
        if (fs.degen) begin
          degen_d = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            qc = (dv_quo_q[DivSteps][k] > ccn_pkg::ONE_Q14) ? ccn_pkg::ONE_Q14
                                                            : dv_quo_q[DivSteps][k];
            nrm_d[k] = fs.neg[k] ? -16'(qc) : 16'(qc);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    normal_x_o     <= nrm_d[0];
    normal_y_o     <= nrm_d[1];
    normal_z_o     <= nrm_d[2];
    surface_kind_o <= kind_d;
    degenerate_o   <= degen_d;
  end

endmodule
`default_nettype wire

// File: rtl/core/capped_cylinder_normal.sv
// Capped cylinder surface normal: top level, register file, front, queue, back.
// Throughput: one item per cycle; the back end drains the queue every cycle,
// so busy stays low and items may follow each other with no gap.
// The depth is set by the 31-stage square root and the 15-stage divider.
// Reset (rst_ni low, asynchronous) clears the configuration registers and empties the pipe.
`default_nettype none
module capped_cylinder_normal (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  // item in
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] point_x_i,
  input  wire logic [15:0] point_y_i,
  input  wire logic [15:0] point_z_i,
  // result out
  output logic             done_o,
  output logic [15:0]      normal_x_o,
  output logic [15:0]      normal_y_o,
  output logic [15:0]      normal_z_o,
  output logic [1:0]       surface_kind_o,
  output logic             degenerate_o
);

  // configuration registers
  logic [47:0] c1_q, c2_q, axis_q, capn1_q, capn2_q;
  logic [14:0] radius_q;
  logic        caps_en_q;
  logic [29:0] r2_q;
  ccn_pkg::reg_idx_e widx;

  assign pready = 1'b1;
  assign widx   = ccn_pkg::reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q      <= '0;
      c2_q      <= '0;
      axis_q    <= '0;
      capn1_q   <= '0;
      capn2_q   <= '0;
      radius_q  <= '0;
      caps_en_q <= 1'b0;
      r2_q      <= '0;
    end else begin
      r2_q <= 30'(radius_q) * 30'(radius_q);
      if (psel && penable && pwrite && pready) begin
        case (widx)
          ccn_pkg::REG_END_ONE: c1_q      <= pwdata[47:0];
          ccn_pkg::REG_END_TWO: c2_q      <= pwdata[47:0];
          ccn_pkg::REG_AXIS:    axis_q    <= pwdata[47:0];
          ccn_pkg::REG_CAP_ONE: capn1_q   <= pwdata[47:0];
          ccn_pkg::REG_CAP_TWO: capn2_q   <= pwdata[47:0];
          ccn_pkg::REG_RADIUS:  radius_q  <= pwdata[14:0];
          ccn_pkg::REG_CAPS_EN: caps_en_q <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // read back
  always_comb begin
    case (widx)
      ccn_pkg::REG_END_ONE: prdata = 64'(c1_q);
      ccn_pkg::REG_END_TWO: prdata = 64'(c2_q);
      ccn_pkg::REG_AXIS:    prdata = 64'(axis_q);
      ccn_pkg::REG_CAP_ONE: prdata = 64'(capn1_q);
      ccn_pkg::REG_CAP_TWO: prdata = 64'(capn2_q);
      ccn_pkg::REG_RADIUS:  prdata = 64'(radius_q);
      ccn_pkg::REG_CAPS_EN: prdata = 64'(caps_en_q);
      default:              prdata = '0;
    endcase
  end

  ccn_pkg::ccn_cfg_t cfg;
  always_comb begin
    cfg.c1      = c1_q;
    cfg.c2      = c2_q;
    cfg.axis    = axis_q;
    cfg.capn1   = capn1_q;
    cfg.capn2   = capn2_q;
    cfg.r2      = r2_q;
    cfg.caps_en = caps_en_q;
  end

  // front, queue, back
  logic               q_full, q_empty, push, pop;
  ccn_pkg::ccn_item_t f_item, q_item;

  assign busy = q_full;

  ccn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (!q_full),
    .in_valid_i (start && !busy),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .cfg_i      (cfg),
    .push_o     (push),
    .item_o     (f_item)
  );

  ccn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_item),
    .pop_i   (pop),
    .data_o  (q_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  ccn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .item_i         (q_item),
    .axis_i         (axis_q),
    .pop_o          (pop),
    .done_o         (done_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .surface_kind_o (surface_kind_o),
    .degenerate_o   (degenerate_o)
  );

`ifndef SYNTH
  // back end drains every cycle, so the queue never fills
  a_queue_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni) !q_full)
    else $error("item queue filled up");
  // a degenerate result is a side result with zero normal
  a_degen_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (surface_kind_o == ccn_pkg::KIND_SIDE &&
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0))
    else $error("degenerate result not a zero side normal");
  // a popped item shows up at the output a fixed time later
  a_pop_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> ##57 done_o)
    else $error("item lost in back end");
`endif

endmodule
`default_nettype wire

// File: bench/capped_cylinder_normal_test.sv
// Self-checking bench for the capped cylinder normal unit: directed table, then random points.
`default_nettype none
module capped_cylinder_normal_test;

  typedef struct packed {
    logic [15:0] nx, ny, nz;
    logic [1:0]  kind;
    logic        degen;
  } normal_t;

  typedef struct {
    logic [15:0] px, py, pz;
    logic        known;
    normal_t     res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic        done_o;
  logic [15:0] normal_x_o, normal_y_o, normal_z_o;
  logic [1:0]  surface_kind_o;
  logic        degenerate_o;

  capped_cylinder_normal dut (.*);

  // shadow copy of the register file
  logic [47:0] sh_c1, sh_c2, sh_axis, sh_n1, sh_n2;
  logic [14:0] sh_radius;
  logic        sh_caps;

  normal_t     pending_normals[$];
  int          mismatches = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("capped_cylinder_normal verification failed");
    $finish;
  end

  function automatic longint comp_of(logic [47:0] r, int k);
    logic signed [15:0] c;
    c = r[16*k +: 16];
    return longint'(c);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit within_cap(longint p[3], logic [47:0] c);
    longint unsigned d2, r2;
    longint d;
    d2 = 0;
    r2 = longint'(sh_radius) * longint'(sh_radius);
    for (int k = 0; k < 3; k++) begin
      d = p[k] - comp_of(c, k);
      d2 += longint'(d * d);
    end
    return d2 <= r2;
  endfunction

  // expected surface normal for one hit point
  function automatic normal_t surface_normal(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    normal_t o;
    longint p[3], v[3], a[3], w[3], dot;
    longint unsigned mag[3], mx, sum, len, q;
    p[0] = longint'($signed(px));
    p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    o = '{nx: '0, ny: '0, nz: '0, kind: ccn_pkg::KIND_SIDE, degen: 1'b0};
    if (sh_caps) begin
      if (within_cap(p, sh_c1)) begin
        o = '{nx: sh_n1[15:0], ny: sh_n1[31:16], nz: sh_n1[47:32],
              kind: ccn_pkg::KIND_CAP_ONE, degen: 1'b0};
        return o;
      end
      if (within_cap(p, sh_c2)) begin
        o = '{nx: sh_n2[15:0], ny: sh_n2[31:16], nz: sh_n2[47:32],
              kind: ccn_pkg::KIND_CAP_TWO, degen: 1'b0};
        return o;
      end
    end
    dot = 0;
    for (int k = 0; k < 3; k++) begin
      v[k] = p[k] - comp_of(sh_c1, k);
      a[k] = comp_of(sh_axis, k);
      dot += v[k] * a[k];
    end
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      w[k] = v[k] * (64'sd1 <<< 28) - dot * a[k];
      mag[k] = w[k] < 0 ? -w[k] : w[k];
      if (mag[k] > mx) mx = mag[k];
    end
    if (mx == 0) begin
      o.degen = 1'b1;
      return o;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
    end
    sum = 0;
    for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
    len = root_floor(sum);
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * 16384 + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      w[k] = w[k] < 0 ? -longint'(q) : longint'(q);
    end
    o.nx = w[0][15:0];
    o.ny = w[1][15:0];
    o.nz = w[2][15:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result checker: the unit cannot be held off, every strobe is one item
  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni && done_o) begin
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected result", 16'(done_o), 16'h0);
      end else begin
        e = pending_normals.pop_front();
        if (normal_x_o !== e.nx) report_mismatch("normal_x", normal_x_o, e.nx);
        if (normal_y_o !== e.ny) report_mismatch("normal_y", normal_y_o, e.ny);
        if (normal_z_o !== e.nz) report_mismatch("normal_z", normal_z_o, e.nz);
        if (surface_kind_o !== e.kind) report_mismatch("kind", 16'(surface_kind_o), 16'(e.kind));
        if (degenerate_o !== e.degen) report_mismatch("degenerate", 16'(degenerate_o), 16'(e.degen));
      end
    end
  end

  task automatic write_reg(ccn_pkg::reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ccn_pkg::REG_END_ONE: sh_c1 = val[47:0];
      ccn_pkg::REG_END_TWO: sh_c2 = val[47:0];
      ccn_pkg::REG_AXIS:    sh_axis = val[47:0];
      ccn_pkg::REG_CAP_ONE: sh_n1 = val[47:0];
      ccn_pkg::REG_CAP_TWO: sh_n2 = val[47:0];
      ccn_pkg::REG_RADIUS:  sh_radius = val[14:0];
      ccn_pkg::REG_CAPS_EN: sh_caps = val[0];
      default: ;
    endcase
  endtask

  // random gap: mostly none or short, now and then long
  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 60) g = 0;
    else if (g < 95) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 70);
    repeat (g) @(posedge clk_i);
  endtask

  // present one item; start stays high over back-to-back items
  task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz, bit keep);
    start <= 1'b1;
    point_x_i <= px; point_y_i <= py; point_z_i <= pz;
    do @(posedge clk_i); while (busy);
    pending_normals.push_back(surface_normal(px, py, pz));
    if (!keep) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_normals.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (70) @(posedge clk_i);
  endtask

  function automatic logic [47:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // point near the cylinder: centre plus small offset, sometimes wide
  function automatic logic [15:0] near(logic [47:0] c, int k);
    int off;
    off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) - 32768
                                      : int'($urandom_range(0, 2047)) - 1024;
    return 16'(comp_of(c, k) + off);
  endfunction

  row_t directed[$];
  normal_t dn;

  initial begin
    sh_c1 = '0; sh_c2 = '0; sh_axis = '0; sh_n1 = '0; sh_n2 = '0;
    sh_radius = '0; sh_caps = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: after reset zero axis, origin gives degenerate side
    dn = '{nx: 16'h0, ny: 16'h0, nz: 16'h0, kind: ccn_pkg::KIND_SIDE, degen: 1'b1};
    directed.push_back('{px: 16'h0, py: 16'h0, pz: 16'h0, known: 1'b1, res: dn});
    dn = '{nx: 16'h4000, ny: 16'h0, nz: 16'h0, kind: ccn_pkg::KIND_SIDE, degen: 1'b0};
    directed.push_back('{px: 16'h7fff, py: 16'h0, pz: 16'h0, known: 1'b1, res: dn});
    dn = '{nx: 16'h0, ny: 16'hc000, nz: 16'h0, kind: ccn_pkg::KIND_SIDE, degen: 1'b0};
    directed.push_back('{px: 16'h0, py: 16'h8000, pz: 16'h0, known: 1'b1, res: dn});
    directed.push_back('{px: 16'h8000, py: 16'h8000, pz: 16'h8000, known: 1'b0, res: dn});
    directed.push_back('{px: 16'h7fff, py: 16'h7fff, pz: 16'h7fff, known: 1'b0, res: dn});
    directed.push_back('{px: 16'h0001, py: 16'hffff, pz: 16'h0001, known: 1'b0, res: dn});
    foreach (directed[i]) begin
      send_point(directed[i].px, directed[i].py, directed[i].pz, 1'b0);
      if (directed[i].known && pending_normals[$] != directed[i].res) begin
        report_mismatch($sformatf("table row %0d", i), pending_normals[$].nx,
                        directed[i].res.nx);
      end
    end
    drain();

    // z axis, caps on, radius 256: caps, side, and on-axis degenerate
    write_reg(ccn_pkg::REG_END_ONE, pack3(0, 0, 0));
    write_reg(ccn_pkg::REG_END_TWO, pack3(0, 0, 2560));
    write_reg(ccn_pkg::REG_AXIS, pack3(0, 0, 16384));
    write_reg(ccn_pkg::REG_CAP_ONE, pack3(0, 0, -16384));
    write_reg(ccn_pkg::REG_CAP_TWO, pack3(0, 0, 16384));
    write_reg(ccn_pkg::REG_RADIUS, 64'd256);
    write_reg(ccn_pkg::REG_CAPS_EN, 64'd1);
    directed.delete();
    directed.push_back('{px: 16'd100, py: 16'd0, pz: 16'd0, known: 1'b0, res: dn});
    directed.push_back('{px: 16'd256, py: 16'd0, pz: 16'd0, known: 1'b0, res: dn});
    directed.push_back('{px: 16'd257, py: 16'd0, pz: 16'd0, known: 1'b0, res: dn});
    directed.push_back('{px: 16'd0, py: 16'd256, pz: 16'd2560, known: 1'b0, res: dn});
    directed.push_back('{px: 16'd256, py: 16'd0, pz: 16'd1280, known: 1'b0, res: dn});
    directed.push_back('{px: 16'd0, py: 16'd0, pz: 16'd1280, known: 1'b0, res: dn});
    directed.push_back('{px: 16'hff00, py: 16'hff00, pz: 16'd640, known: 1'b0, res: dn});
    foreach (directed[i]) send_point(directed[i].px, directed[i].py, directed[i].pz, 1'b1);
    start <= 1'b0;
    drain();

    // largest radius, extreme first centre and non-unit axis
    write_reg(ccn_pkg::REG_RADIUS, 64'h7fff);
    write_reg(ccn_pkg::REG_END_ONE, pack3(-32768, -32768, -32768));
    write_reg(ccn_pkg::REG_AXIS, pack3(-32768, 32767, -1));
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    drain();
    write_reg(ccn_pkg::REG_CAPS_EN, 64'd0);
    send_point(16'h7fff, 16'h8000, 16'h7fff, 1'b0);
    drain();

    // random phases, each with fresh configuration
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(ccn_pkg::REG_END_ONE, {$urandom, $urandom});
      write_reg(ccn_pkg::REG_END_TWO, {$urandom, $urandom});
      if (ph % 3 == 0) begin
        write_reg(ccn_pkg::REG_END_ONE, pack3(int'($urandom_range(0, 4095)) - 2048, 0, 0));
        write_reg(ccn_pkg::REG_END_TWO, pack3(0, int'($urandom_range(0, 4095)) - 2048, 1024));
      end
      write_reg(ccn_pkg::REG_AXIS, (ph % 2) ? {$urandom, $urandom}
                                            : pack3(0, ph % 4 ? 16384 : -16384, 0));
      write_reg(ccn_pkg::REG_CAP_ONE, {$urandom, $urandom});
      write_reg(ccn_pkg::REG_CAP_TWO, {$urandom, $urandom});
      write_reg(ccn_pkg::REG_RADIUS, (ph == 9) ? 64'h7fff : 64'($urandom_range(0, 1200)));
      write_reg(ccn_pkg::REG_CAPS_EN, 64'(ph != 4));
      for (int n = 0; n < 125; n++) begin
        bit keep;
        keep = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 2) == 0)
          send_point(16'($urandom), 16'($urandom), 16'($urandom), keep);
        else if ($urandom_range(0, 1) == 0)
          send_point(near(sh_c1, 0), near(sh_c1, 1), near(sh_c1, 2), keep);
        else
          send_point(near(sh_c2, 0), near(sh_c2, 1), near(sh_c2, 2), keep);
        if (!keep) idle_gap();
        if (n == 60 && ph == 2) begin
          start <= 1'b0;
          drain();
        end
      end
      start <= 1'b0;
      drain();
    end

    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("capped_cylinder_normal verification clean");
    end else begin
      $display("capped_cylinder_normal verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
